// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst, pre, post, msg)
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif

`endif

// ===== hdl/wcf_pkg.sv =====
// ----------------------------------------------------------------------------
// Word CRC-8 framer/deframer package
// Command codes, result record, receive status and the CRC-8 byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package wcf_pkg;

   typedef enum logic [1:0] {
      CMD_SEND_CODE = 2'd0,
      CMD_SEND_ARG  = 2'd1,
      CMD_RX_BYTE   = 2'd2,
      CMD_CLEAR     = 2'd3
   } cmd_type;

   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_TOP  = 8'h80;

   typedef struct packed {
      logic [7:0]  tx_byte;
      logic        tx_valid;
      logic [15:0] rx_word;
      logic        rx_word_valid;
      logic        crc_ok;
      logic        failed_sticky;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] word;
      logic        complete;
      logic        crc_ok;
      logic        failed_cur;
      logic        failed_next;
   } rx_status_type;

   // MSB-first CRC-8 update over one byte
   function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] b);
      logic [7:0] r;
      r = acc ^ b;
      for (int k = 0; k < 8; k++) begin
         if ((r & CRC_TOP) != 8'h00) begin
            r = {r[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            r = {r[6:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/wcf_rx.sv =====
// ----------------------------------------------------------------------------
// Word CRC-8 deframer
// Gathers received bytes in groups of three, keeps a running CRC over the
// first two and holds the sticky bad-CRC flag.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module wcf_rx (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,      // commit the held transaction
   input  wire wcf_pkg::cmd_type      cmd,
   input  wire logic [7:0]            rx_byte,
   input  wire logic                  fin,
   output wcf_pkg::rx_status_type     status
);
   import wcf_pkg::*;

   logic [1:0]  phase_ff, phase_in;
   logic [15:0] held_ff, held_in;
   logic [7:0]  crc_ff, crc_in;
   logic        fail_ff, fail_in;
   logic [1:0]  ph;
   logic        ok;

   always_comb begin
      // an unused phase code counts as the start of a group
      ph = (phase_ff == 2'd3) ? 2'd0 : phase_ff;
      ok = (crc_ff == rx_byte);

      status.word        = held_ff;
      status.complete    = (cmd == CMD_RX_BYTE) && (ph == 2'd2);
      status.crc_ok      = ok;
      status.failed_cur  = fail_ff;
      status.failed_next = fail_ff | (status.complete & ~ok);

      phase_in = phase_ff;
      held_in  = held_ff;
      crc_in   = crc_ff;
      fail_in  = fail_ff;
      if (step) begin
         unique case (cmd)
            CMD_RX_BYTE: begin
               if (ph == 2'd0) begin
                  held_in  = {rx_byte, 8'h00};
                  crc_in   = crc8_byte(CRC_INIT, rx_byte);
                  phase_in = fin ? 2'd0 : 2'd1;
               end else if (ph == 2'd1) begin
                  held_in  = {held_ff[15:8], rx_byte};
                  crc_in   = crc8_byte(crc_ff, rx_byte);
                  phase_in = fin ? 2'd0 : 2'd2;
               end else begin
                  phase_in = 2'd0;
                  fail_in  = status.failed_next;
               end
            end
            CMD_CLEAR: begin
               phase_in = 2'd0;
               held_in  = 16'h0000;
               fail_in  = 1'b0;
            end
            default: begin
               // transmit transactions leave the receiver alone
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
         held_ff  <= 16'h0000;
         fail_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         fail_ff  <= fail_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
   end

   `ASSERT_NEXT(a_clear_resets, clock, reset, step && (cmd == CMD_CLEAR), !fail_ff && (phase_ff == 2'd0), "clear left receiver state")
   `ASSERT_NEXT(a_fail_sticky, clock, reset, fail_ff && !(step && (cmd == CMD_CLEAR)), fail_ff, "failure flag dropped without clear")
   `ASSERT_IMPLY(a_fail_cause, clock, reset, $rose(fail_ff), $past(step && status.complete && !ok), "failure flag set without bad CRC")

endmodule

`default_nettype wire

// ===== hdl/word_crc8_framer_deframer.sv =====
// ----------------------------------------------------------------------------
// Word CRC-8 framer/deframer
// Turns command codes and argument words into bus bytes with CRC-8 (0x31,
// initial 0xFF) and gathers received byte triplets into checked words.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: tuser = command (0 send code, 1 send argument, 2 received
//   byte, 3 clear receiver), tdata = word or received byte, tlast = final
//   word or byte of a transfer.
//   rsp channel: one byte to transmit or one received word per transaction,
//   tlast on the final result of a transaction that came in with tlast.
//   Each request is held in an input register; its results are registered
//   in a single output register, one result per cycle while rsp_tready is
//   high. A send code emits two bytes, a send argument three (high byte, low
//   byte, CRC), a completing received byte one word and other requests none;
//   the next request is taken in the cycle the current one issues its final
//   result, so throughput is set by the single result register.
//   Reset (synchronous) empties both registers and clears the receive phase,
//   held bytes and the sticky failure flag.
//   While rsp_tready is low the result holds; the input register still takes
//   a request if empty, then req_tready drops until results move on.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module word_crc8_framer_deframer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] data_word
   input  wire logic [1:0]  req_tuser,   // [1:0] cmd
   input  wire logic        req_tlast,   // final_req
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata,   // [7:0] tx_byte, [23:8] rx_word,
                                         // [24] crc_ok, [25] failed_sticky, zero
   output      logic [1:0]  rsp_tuser,   // [0] tx_valid, [1] rx_word_valid
   output      logic        rsp_tlast    // last
);
   import wcf_pkg::*;

   logic          in_vld_ff, in_vld_in;
   cmd_type       in_cmd_ff;
   logic [15:0]   in_data_ff;
   logic          in_fin_ff;
   logic [1:0]    idx_ff, idx_in;
   logic          out_vld_ff, out_vld_in;
   rsp_type       out_ff, out_in;

   rx_status_type rx_st;
   logic [1:0]    cnt;
   logic          has_rsp;
   logic          out_free;
   logic          is_final;
   logic          emit;
   logic          done;
   logic          req_take;
   logic [7:0]    arg_crc;

   wcf_rx u_rx (
      .clock   (clock),
      .reset   (reset),
      .step    (done),
      .cmd     (in_cmd_ff),
      .rx_byte (in_data_ff[7:0]),
      .fin     (in_fin_ff),
      .status  (rx_st)
   );

   always_comb begin
      unique case (in_cmd_ff)
         CMD_SEND_CODE: cnt = 2'd2;
         CMD_SEND_ARG:  cnt = 2'd3;
         CMD_RX_BYTE:   cnt = {1'b0, rx_st.complete};
         CMD_CLEAR:     cnt = 2'd0;
         default:       cnt = 2'd0;
      endcase
      has_rsp  = (cnt != 2'd0);
      out_free = !out_vld_ff || rsp_tready;
      is_final = (idx_ff == (cnt - 2'd1));
      emit     = in_vld_ff && has_rsp && out_free;
      done     = in_vld_ff && (!has_rsp || (out_free && is_final));
      req_tready = !in_vld_ff || done;
      req_take   = req_tvalid && req_tready;

      arg_crc = crc8_byte(crc8_byte(CRC_INIT, in_data_ff[15:8]), in_data_ff[7:0]);

      out_in = '0;
      if (in_cmd_ff == CMD_RX_BYTE) begin
         out_in.rx_word       = rx_st.word;
         out_in.rx_word_valid = 1'b1;
         out_in.crc_ok        = rx_st.crc_ok;
         out_in.failed_sticky = rx_st.failed_next;
         out_in.last          = in_fin_ff;
      end else begin
         case (idx_ff)
            2'd0:    out_in.tx_byte = in_data_ff[15:8];
            2'd1:    out_in.tx_byte = in_data_ff[7:0];
            default: out_in.tx_byte = arg_crc;
         endcase
         out_in.tx_valid      = 1'b1;
         out_in.failed_sticky = rx_st.failed_cur;
         out_in.last          = is_final && in_fin_ff;
      end

      idx_in = idx_ff;
      if (done) begin
         idx_in = 2'd0;
      end else if (emit) begin
         idx_in = idx_ff + 2'd1;
      end

      in_vld_in = in_vld_ff;
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (done) begin
         in_vld_in = 1'b0;
      end

      out_vld_in = out_vld_ff;
      if (emit) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         idx_ff     <= 2'd0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         idx_ff     <= idx_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload: load on transaction, hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff  <= cmd_type'(req_tuser);
         in_data_ff <= req_tdata;
         in_fin_ff  <= req_tlast;
      end
      if (emit) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {6'b000000, out_ff.failed_sticky, out_ff.crc_ok,
                        out_ff.rx_word, out_ff.tx_byte};
   assign rsp_tuser  = {out_ff.rx_word_valid, out_ff.tx_valid};
   assign rsp_tlast  = out_ff.last;

   `ASSERT_IMPLY(a_no_overwrite, clock, reset, req_tvalid && req_tready, !in_vld_ff || done, "held request overwritten")
   `ASSERT_IMPLY(a_idle_index, clock, reset, !in_vld_ff, idx_ff == 2'd0, "result index not reset when idle")
   `ASSERT_NEXT(a_hold_pending, clock, reset, in_vld_ff && !done, in_vld_ff, "request dropped before its results")
   `ASSERT_IMPLY(a_kind_exclusive, clock, reset, out_vld_ff, out_ff.tx_valid != out_ff.rx_word_valid, "result kind ambiguous")

endmodule

`default_nettype wire
